@@ src/mite_pkg.sv @@
// Shared constants, opcodes and interface types of the I-type execute unit.
package mite_pkg;

    // Data memory geometry: big-endian bytes stored as 32-bit rows of four.
    localparam int DMEM_BYTES = 1024;
    localparam int DMEM_ROWS  = DMEM_BYTES / 4;
    localparam int DMEM_ROW_W = $clog2(DMEM_ROWS);

    // Register file geometry.
    localparam int RF_DEPTH  = 32;
    localparam int RF_ADDR_W = 5;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 80;

    // Primary opcodes.
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_BGTZ  = 6'h07;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_NORI  = 6'h0e;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2b;

    // Memory access sizes in bytes.
    localparam logic [2:0] SZ_NONE = 3'd0;
    localparam logic [2:0] SZ_BYTE = 3'd1;
    localparam logic [2:0] SZ_HALF = 3'd2;
    localparam logic [2:0] SZ_WORD = 3'd4;

    // How a loaded row is turned into a register value.
    typedef enum logic [2:0] {
        LD_WORD,
        LD_HALF,
        LD_HALF_U,
        LD_BYTE,
        LD_BYTE_U
    } t_ld_kind;

    // Register file write port.
    typedef struct packed {
        logic                 en;
        logic [RF_ADDR_W-1:0] addr;
        logic [31:0]          data;
    } t_rf_wr;

    // Data memory access request; byte enable bit 3 is the lowest byte address.
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [3:0]            be;
        logic [DMEM_ROW_W-1:0] row;
        logic [31:0]           wdata;
    } t_dmem_req;

endpackage

@@ src/mite_regfile.sv @@
// Register file of 32 words with registered dual read and write bypass.
module mite_regfile (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [mite_pkg::RF_ADDR_W-1:0]    i_rd_addr_a,
    input  logic [mite_pkg::RF_ADDR_W-1:0]    i_rd_addr_b,
    input  mite_pkg::t_rf_wr                  i_wr,
    output logic [31:0]                       o_rd_a,
    output logic [31:0]                       o_rd_b
);

    logic [31:0]                     r_mem [mite_pkg::RF_DEPTH];
    logic [mite_pkg::RF_DEPTH-1:0]   r_vld;
    logic [31:0]                     r_rd_a;
    logic [31:0]                     r_rd_b;

    // Entries read as zero until their first write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered reads; a write at the same edge is passed straight through.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr_a)) begin
                r_rd_a <= i_wr.data;
            end else begin
                r_rd_a <= r_vld[i_rd_addr_a] ? r_mem[i_rd_addr_a] : 32'd0;
            end
            if (i_wr.en && (i_wr.addr == i_rd_addr_b)) begin
                r_rd_b <= i_wr.data;
            end else begin
                r_rd_b <= r_vld[i_rd_addr_b] ? r_mem[i_rd_addr_b] : 32'd0;
            end
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ src/mite_dmem.sv @@
// Data memory of 32-bit rows with byte enables, registered read and clearing pass.
module mite_dmem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mite_pkg::t_dmem_req  i_req,
    output logic [31:0]          o_rd_row,
    output logic                 o_busy
);

    logic [31:0]                     r_mem [mite_pkg::DMEM_ROWS];
    logic [31:0]                     r_rd_row;
    logic                            r_clr_busy;
    logic [mite_pkg::DMEM_ROW_W-1:0] r_clr_row;

    logic                            wr_en;
    logic [3:0]                      wr_be;
    logic [mite_pkg::DMEM_ROW_W-1:0] wr_row;
    logic [31:0]                     wr_data;

    // Clearing pass sweeps every row once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == mite_pkg::DMEM_ROW_W'(mite_pkg::DMEM_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // The clearing pass owns the write port while it runs.
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_be   = 4'b1111;
            wr_row  = r_clr_row;
            wr_data = 32'd0;
        end else begin
            wr_en   = i_req.wr_en;
            wr_be   = i_req.be;
            wr_row  = i_req.row;
            wr_data = i_req.wdata;
        end
    end

    // Byte-lane writes and registered row read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int k = 0; k < 4; k++) begin
                if (wr_be[k]) begin
                    r_mem[wr_row][8*k +: 8] <= wr_data[8*k +: 8];
                end
            end
        end
        if (i_req.rd_en) begin
            r_rd_row <= r_mem[i_req.row];
        end
    end

    assign o_rd_row = r_rd_row;
    assign o_busy   = r_clr_busy;

endmodule

@@ src/mips_itype_execute_with_faults.sv @@
// Top level of the I-type execute unit: two-stage pipeline with fault flags.
//
// Channel   Direction  Transaction carries
// s_axis    in         one instruction: opcode, rs, rt, immediate, pc
// m_axis    out        one result: next pc, register write, fault flags
//
// One instruction is taken every cycle unless the memory clear or a stalled m_axis
// holds s_axis tready low: register read as it is taken, execute and memory access
// in the first stage, result register with load extraction and write-back in the second.
// After reset the data memory is swept clear, one row a cycle, with s_axis tready
// low. A stalled m_axis holds both stages.
module mips_itype_execute_with_faults (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [5:0] opcode, [10:6] src_reg, [15:11] tgt_reg, [31:16] immediate,
    // [63:32] current_pc
    input  logic [mite_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] next_pc, [32] reg_written, [37:33] dest_index, [69:38] written_value,
    // [70] zero_write_fault, [71] number_overflow, [72] address_fault,
    // [73] misaligned_fault, [74] illegal_opcode, [79:75] zero
    output logic [mite_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    // Stage one: decoded instruction fields, operands come from the register file.
    logic        r_s1_vld;
    logic [5:0]  r_s1_op;
    logic [4:0]  r_s1_rs;
    logic [4:0]  r_s1_rt;
    logic [15:0] r_s1_imm;
    logic [31:0] r_s1_pc;

    // Stage two: result register.
    logic                 r_s2_vld;
    logic [31:0]          r_s2_next_pc;
    logic                 r_s2_done;
    logic [4:0]           r_s2_rt;
    logic [31:0]          r_s2_val;
    logic                 r_s2_is_load;
    mite_pkg::t_ld_kind   r_s2_ld_kind;
    logic [1:0]           r_s2_ofs;
    logic                 r_s2_zfault;
    logic                 r_s2_ovf;
    logic                 r_s2_afault;
    logic                 r_s2_mfault;
    logic                 r_s2_ill;

    logic                 n_s2_done;
    logic [4:0]           n_s2_rt;
    logic [31:0]          n_s2_next_pc;
    logic [31:0]          n_s2_val;
    logic                 n_s2_is_load;
    mite_pkg::t_ld_kind   n_s2_ld_kind;
    logic                 n_s2_zfault;
    logic                 n_s2_ovf;
    logic                 n_s2_afault;
    logic                 n_s2_mfault;
    logic                 n_s2_ill;

    logic                 s_accept;
    logic                 adv_s2;
    logic                 adv_s1;
    logic                 mem_busy;

    logic [31:0]          rf_a;
    logic [31:0]          rf_b;
    logic [31:0]          op_a;
    logic [31:0]          op_b;
    logic [31:0]          rd_row;
    logic [31:0]          ld_val;
    logic [31:0]          s2_value;

    logic [31:0]          simm;
    logic [31:0]          zimm;
    logic [31:0]          sum;
    logic                 sum_ovf;
    logic [31:0]          br_off;
    logic [31:0]          pc4;
    logic [31:0]          br_sum;
    logic                 br_ovf;
    logic                 is_writer;
    logic                 is_store;
    logic                 is_branch;
    logic                 taken;
    logic [2:0]           acc_size;
    logic                 access_ok;

    mite_pkg::t_rf_wr     rf_wr;
    mite_pkg::t_dmem_req  dmem_req;

    // Pipeline flow control.
    assign adv_s2          = !r_s2_vld || i_m_axis_tready;
    assign adv_s1          = r_s1_vld && adv_s2;
    assign o_s_axis_tready = !mem_busy && (!r_s1_vld || adv_s2);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Stage one register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_accept) begin
            r_s1_vld <= 1'b1;
        end else if (adv_s2) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_op  <= i_s_axis_tdata[5:0];
            r_s1_rs  <= i_s_axis_tdata[10:6];
            r_s1_rt  <= i_s_axis_tdata[15:11];
            r_s1_imm <= i_s_axis_tdata[31:16];
            r_s1_pc  <= i_s_axis_tdata[63:32];
        end
    end

    // Register file, read as the instruction is taken, written from the result stage.
    assign rf_wr.en   = r_s2_vld && r_s2_done;
    assign rf_wr.addr = r_s2_rt;
    assign rf_wr.data = s2_value;

    mite_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (i_s_axis_tdata[10:6]),
        .i_rd_addr_b (i_s_axis_tdata[15:11]),
        .i_wr        (rf_wr),
        .o_rd_a      (rf_a),
        .o_rd_b      (rf_b)
    );

    // Forward the older instruction in the result stage, which may be a load.
    assign op_a = (r_s2_vld && r_s2_done && (r_s2_rt == r_s1_rs)) ? s2_value : rf_a;
    assign op_b = (r_s2_vld && r_s2_done && (r_s2_rt == r_s1_rt)) ? s2_value : rf_b;

    // Shared adders of the execute stage.
    always_comb begin
        simm    = {{16{r_s1_imm[15]}}, r_s1_imm};
        zimm    = {16'd0, r_s1_imm};
        sum     = op_a + simm;
        sum_ovf = (op_a[31] == simm[31]) && (sum[31] != op_a[31]);
        br_off  = {simm[29:0], 2'b00};
        pc4     = r_s1_pc + 32'd4;
        br_sum  = pc4 + br_off;
        br_ovf  = (pc4[31] == br_off[31]) && (br_sum[31] != pc4[31]);
    end

    // Opcode decode and execute.
    always_comb begin
        is_writer    = 1'b0;
        is_store     = 1'b0;
        is_branch    = 1'b0;
        taken        = 1'b0;
        acc_size     = mite_pkg::SZ_NONE;
        n_s2_is_load = 1'b0;
        n_s2_ld_kind = mite_pkg::LD_WORD;
        n_s2_val     = 32'd0;
        n_s2_ovf     = 1'b0;
        n_s2_ill     = 1'b0;
        unique case (r_s1_op)
            mite_pkg::OP_ADDI: begin
                is_writer = 1'b1;
                n_s2_val  = sum;
                n_s2_ovf  = sum_ovf;
            end
            mite_pkg::OP_ADDIU: begin
                is_writer = 1'b1;
                n_s2_val  = sum;
            end
            mite_pkg::OP_LW: begin
                is_writer    = 1'b1;
                n_s2_is_load = 1'b1;
                acc_size     = mite_pkg::SZ_WORD;
                n_s2_ld_kind = mite_pkg::LD_WORD;
            end
            mite_pkg::OP_LH: begin
                is_writer    = 1'b1;
                n_s2_is_load = 1'b1;
                acc_size     = mite_pkg::SZ_HALF;
                n_s2_ld_kind = mite_pkg::LD_HALF;
            end
            mite_pkg::OP_LHU: begin
                is_writer    = 1'b1;
                n_s2_is_load = 1'b1;
                acc_size     = mite_pkg::SZ_HALF;
                n_s2_ld_kind = mite_pkg::LD_HALF_U;
            end
            mite_pkg::OP_LB: begin
                is_writer    = 1'b1;
                n_s2_is_load = 1'b1;
                acc_size     = mite_pkg::SZ_BYTE;
                n_s2_ld_kind = mite_pkg::LD_BYTE;
            end
            mite_pkg::OP_LBU: begin
                is_writer    = 1'b1;
                n_s2_is_load = 1'b1;
                acc_size     = mite_pkg::SZ_BYTE;
                n_s2_ld_kind = mite_pkg::LD_BYTE_U;
            end
            mite_pkg::OP_SW: begin
                is_store = 1'b1;
                acc_size = mite_pkg::SZ_WORD;
            end
            mite_pkg::OP_SH: begin
                is_store = 1'b1;
                acc_size = mite_pkg::SZ_HALF;
            end
            mite_pkg::OP_SB: begin
                is_store = 1'b1;
                acc_size = mite_pkg::SZ_BYTE;
            end
            mite_pkg::OP_LUI: begin
                is_writer = 1'b1;
                n_s2_val  = {r_s1_imm, 16'd0};
            end
            mite_pkg::OP_ANDI: begin
                is_writer = 1'b1;
                n_s2_val  = op_a & zimm;
            end
            mite_pkg::OP_ORI: begin
                is_writer = 1'b1;
                n_s2_val  = op_a | zimm;
            end
            mite_pkg::OP_NORI: begin
                is_writer = 1'b1;
                n_s2_val  = ~(op_a | zimm);
            end
            mite_pkg::OP_SLTI: begin
                is_writer = 1'b1;
                n_s2_val  = {31'd0, ($signed(op_a) < $signed(simm))};
            end
            mite_pkg::OP_BEQ: begin
                is_branch = 1'b1;
                taken     = (op_a == op_b);
            end
            mite_pkg::OP_BNE: begin
                is_branch = 1'b1;
                taken     = (op_a != op_b);
            end
            mite_pkg::OP_BGTZ: begin
                is_branch = 1'b1;
                taken     = (op_a != 32'd0) && !op_a[31];
            end
            default: begin
                n_s2_ill = 1'b1;
            end
        endcase

        // Branch target and its overflow check.
        n_s2_next_pc = r_s1_pc;
        if (is_branch) begin
            n_s2_ovf = br_ovf;
            if (taken) begin
                n_s2_next_pc = r_s1_pc + br_off;
            end
        end

        // Address range and alignment of a memory access.
        n_s2_afault = 1'b0;
        n_s2_mfault = 1'b0;
        if (acc_size != mite_pkg::SZ_NONE) begin
            n_s2_ovf    = sum_ovf;
            n_s2_afault = (({1'b0, sum} + 33'(acc_size)) > 33'(mite_pkg::DMEM_BYTES));
            if (acc_size == mite_pkg::SZ_WORD) begin
                n_s2_mfault = (sum[1:0] != 2'b00);
            end else if (acc_size == mite_pkg::SZ_HALF) begin
                n_s2_mfault = sum[0];
            end
        end
        access_ok = (acc_size != mite_pkg::SZ_NONE) && !n_s2_afault && !n_s2_mfault;

        // A faulting load writes nothing; register zero is never written.
        n_s2_zfault = is_writer && (r_s1_rt == 5'd0);
        n_s2_done   = is_writer && (!n_s2_is_load || access_ok) && (r_s1_rt != 5'd0);
        n_s2_rt     = n_s2_done ? r_s1_rt : 5'd0;
    end

    // Data memory request, issued as the instruction leaves the execute stage.
    always_comb begin
        dmem_req.rd_en = adv_s1 && n_s2_is_load && access_ok;
        dmem_req.wr_en = adv_s1 && is_store && access_ok;
        dmem_req.row   = sum[mite_pkg::DMEM_ROW_W+1:2];
        case (acc_size)
            mite_pkg::SZ_WORD: begin
                dmem_req.be    = 4'b1111;
                dmem_req.wdata = op_b;
            end
            mite_pkg::SZ_HALF: begin
                dmem_req.be    = sum[1] ? 4'b0011 : 4'b1100;
                dmem_req.wdata = {2{op_b[15:0]}};
            end
            default: begin
                dmem_req.be    = 4'b1000 >> sum[1:0];
                dmem_req.wdata = {4{op_b[7:0]}};
            end
        endcase
    end

    mite_dmem u_dmem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (dmem_req),
        .o_rd_row (rd_row),
        .o_busy   (mem_busy)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv_s2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_s2_next_pc <= n_s2_next_pc;
            r_s2_done    <= n_s2_done;
            r_s2_rt      <= n_s2_rt;
            r_s2_val     <= n_s2_val;
            r_s2_is_load <= n_s2_is_load;
            r_s2_ld_kind <= n_s2_ld_kind;
            r_s2_ofs     <= sum[1:0];
            r_s2_zfault  <= n_s2_zfault;
            r_s2_ovf     <= n_s2_ovf;
            r_s2_afault  <= n_s2_afault;
            r_s2_mfault  <= n_s2_mfault;
            r_s2_ill     <= n_s2_ill;
        end
    end

    // Pick and extend the loaded bytes; the lowest address is the top byte of a row.
    always_comb begin
        case (r_s2_ld_kind)
            mite_pkg::LD_HALF: begin
                ld_val = {{16{rd_row[{~r_s2_ofs[1], 4'b1111}]}},
                          rd_row[{~r_s2_ofs[1], 4'b0000} +: 16]};
            end
            mite_pkg::LD_HALF_U: begin
                ld_val = {16'd0, rd_row[{~r_s2_ofs[1], 4'b0000} +: 16]};
            end
            mite_pkg::LD_BYTE: begin
                ld_val = {{24{rd_row[{~r_s2_ofs, 3'b111}]}},
                          rd_row[{~r_s2_ofs, 3'b000} +: 8]};
            end
            mite_pkg::LD_BYTE_U: begin
                ld_val = {24'd0, rd_row[{~r_s2_ofs, 3'b000} +: 8]};
            end
            default: begin
                ld_val = rd_row;
            end
        endcase
    end

    assign s2_value = r_s2_is_load ? ld_val : r_s2_val;

    // Output transaction.
    assign o_m_axis_tvalid = r_s2_vld;
    assign o_m_axis_tdata  = {5'd0, r_s2_ill, r_s2_mfault, r_s2_afault, r_s2_ovf,
                              r_s2_zfault, (r_s2_done ? s2_value : 32'd0),
                              r_s2_rt, r_s2_done, r_s2_next_pc};

endmodule

@@ test/mips_itype_execute_with_faults_tb.sv @@
// Self-checking testbench for the I-type execute unit: directed table, then random programs.
`timescale 1ns / 100ps

module mips_itype_execute_with_faults_tb;

    // Opcodes at both ends of the field that the unit does not implement.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_TOP     = 6'h3f;

    // Receiver hold-off length used to back the pipeline up into its input.
    localparam int RX_HOLD_CYCLES = 120;
    // Random instructions issued in each idle setting.
    localparam int ITEMS_PER_PHASE = 650;
    // Cycles to wait after the last result before closing the run.
    localparam int TAIL_CYCLES = 10;
    // Byte index width of the mirrored data memory.
    localparam int DMEM_IDX_W = $clog2(mite_pkg::DMEM_BYTES);

    // Instruction transaction, opcode in the lowest bits.
    typedef struct packed {
        logic [31:0] pc;
        logic [15:0] imm;
        logic [4:0]  rt;
        logic [4:0]  rs;
        logic [5:0]  op;
    } t_instr;

    // Result transaction, next pc in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic        ill;
        logic        mis;
        logic        afl;
        logic        ovf;
        logic        zwf;
        logic [31:0] wval;
        logic [4:0]  dest;
        logic        wr;
        logic [31:0] npc;
    } t_result;

    // One row of the directed table; a typed row carries its own expected result.
    typedef struct {
        t_instr  ins;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [mite_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [mite_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Mirror of the architectural state.
    logic [31:0] gpr [32];
    logic [7:0]  dmem [mite_pkg::DMEM_BYTES];

    t_result     pending_results [$];
    t_dir_row    dir_tab [$];
    int unsigned n_errors = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          rx_hold_request = 1'b0;

    mips_itype_execute_with_faults dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run-away guard.
    initial begin
        #10_000_000;
        $display("mips_itype_execute_with_faults: mismatch");
        $finish;
    end

    function automatic t_instr instr(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                     logic [15:0] imm, logic [31:0] pc);
        t_instr ins;
        ins.op  = op;
        ins.rs  = rs;
        ins.rt  = rt;
        ins.imm = imm;
        ins.pc  = pc;
        return ins;
    endfunction

    function automatic t_result outcome(logic [31:0] npc, logic wr, logic [4:0] dest,
                                        logic [31:0] wval, logic zwf, logic ovf,
                                        logic afl, logic mis, logic ill);
        t_result res;
        res      = '0;
        res.npc  = npc;
        res.wr   = wr;
        res.dest = dest;
        res.wval = wval;
        res.zwf  = zwf;
        res.ovf  = ovf;
        res.afl  = afl;
        res.mis  = mis;
        res.ill  = ill;
        return res;
    endfunction

    // Access size in bytes of a load or store, zero for anything else.
    function automatic logic [2:0] mem_size(logic [5:0] op);
        case (op)
            mite_pkg::OP_LW, mite_pkg::OP_SW:
                return mite_pkg::SZ_WORD;
            mite_pkg::OP_LH, mite_pkg::OP_LHU, mite_pkg::OP_SH:
                return mite_pkg::SZ_HALF;
            mite_pkg::OP_LB, mite_pkg::OP_LBU, mite_pkg::OP_SB:
                return mite_pkg::SZ_BYTE;
            default:
                return mite_pkg::SZ_NONE;
        endcase
    endfunction

    function automatic logic add_overflows(logic [31:0] x, logic [31:0] y);
        logic [31:0] s;
        s = x + y;
        return (x[31] == y[31]) && (s[31] != x[31]);
    endfunction

    // Executes one instruction on the mirrored state and returns its result.
    function automatic t_result execute_itype(t_instr ins);
        t_result               res;
        logic [31:0]           a, b, simm, zimm, addr, val;
        logic [2:0]            sz;
        logic [DMEM_IDX_W-1:0] idx;
        bit                    writes, writer, branch, taken;
        longint unsigned       span;
        res    = '0;
        a      = gpr[ins.rs];
        b      = gpr[ins.rt];
        simm   = {{16{ins.imm[15]}}, ins.imm};
        zimm   = {16'h0, ins.imm};
        addr   = a + simm;
        val    = '0;
        writes = 1'b0;
        branch = 1'b0;
        taken  = 1'b0;
        sz     = mem_size(ins.op);
        res.npc = ins.pc;

        case (ins.op)
            mite_pkg::OP_ADDI: begin
                writes  = 1'b1;
                val     = a + simm;
                res.ovf = add_overflows(a, simm);
            end
            mite_pkg::OP_ADDIU: begin
                writes = 1'b1;
                val    = a + simm;
            end
            mite_pkg::OP_LUI: begin
                writes = 1'b1;
                val    = {ins.imm, 16'h0};
            end
            mite_pkg::OP_ANDI: begin
                writes = 1'b1;
                val    = a & zimm;
            end
            mite_pkg::OP_ORI: begin
                writes = 1'b1;
                val    = a | zimm;
            end
            mite_pkg::OP_NORI: begin
                writes = 1'b1;
                val    = ~(a | zimm);
            end
            mite_pkg::OP_SLTI: begin
                writes = 1'b1;
                val    = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            end
            mite_pkg::OP_LW, mite_pkg::OP_LH, mite_pkg::OP_LHU, mite_pkg::OP_LB,
            mite_pkg::OP_LBU: begin
                writes = 1'b1;
            end
            mite_pkg::OP_SW, mite_pkg::OP_SH, mite_pkg::OP_SB: begin
            end
            mite_pkg::OP_BEQ: begin
                branch = 1'b1;
                taken  = (a == b);
            end
            mite_pkg::OP_BNE: begin
                branch = 1'b1;
                taken  = (a != b);
            end
            mite_pkg::OP_BGTZ: begin
                branch = 1'b1;
                taken  = (a != 0) && !a[31];
            end
            default: begin
                res.ill = 1'b1;
            end
        endcase
        writer = writes;

        // Branch target overflow is reported whether or not the branch is taken.
        if (branch) begin
            res.ovf = add_overflows(ins.pc + 32'd4, simm << 2);
            if (taken)
                res.npc = ins.pc + (simm << 2);
        end

        // Loads and stores: a faulting access is skipped entirely.
        if (sz != mite_pkg::SZ_NONE) begin
            res.ovf = add_overflows(a, simm);
            span    = {32'h0, addr} + 64'(sz);
            res.afl = span > 64'(mite_pkg::DMEM_BYTES);
            res.mis = (sz == mite_pkg::SZ_WORD && addr[1:0] != 2'b00) ||
                      (sz == mite_pkg::SZ_HALF && addr[0]);
            if (res.afl || res.mis) begin
                writes = 1'b0;
            end else begin
                idx = addr[DMEM_IDX_W-1:0];
                case (ins.op)
                    mite_pkg::OP_LW:
                        val = {dmem[idx], dmem[idx+1'b1], dmem[idx+2'd2], dmem[idx+2'd3]};
                    mite_pkg::OP_LH:
                        val = {{16{dmem[idx][7]}}, dmem[idx], dmem[idx+1'b1]};
                    mite_pkg::OP_LHU:
                        val = {16'h0, dmem[idx], dmem[idx+1'b1]};
                    mite_pkg::OP_LB:
                        val = {{24{dmem[idx][7]}}, dmem[idx]};
                    mite_pkg::OP_LBU:
                        val = {24'h0, dmem[idx]};
                    mite_pkg::OP_SW:
                        {dmem[idx], dmem[idx+1'b1], dmem[idx+2'd2], dmem[idx+2'd3]} = b;
                    mite_pkg::OP_SH:
                        {dmem[idx], dmem[idx+1'b1]} = b[15:0];
                    mite_pkg::OP_SB:
                        dmem[idx] = b[7:0];
                    default: ;
                endcase
            end
        end

        // Register zero is never written; naming it as destination is a fault.
        res.zwf = writer && (ins.rt == 5'd0);
        if (writes && ins.rt != 5'd0) begin
            gpr[ins.rt] = val;
            res.wr      = 1'b1;
            res.dest    = ins.rt;
            res.wval    = val;
        end
        return res;
    endfunction

    // Offers one instruction transaction and records its expected result once taken.
    task automatic send_instr(t_instr ins, bit typed, t_result typed_res);
        t_result pred;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ins;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = execute_itype(ins);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Stops offering until every outstanding result has been delivered.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Builds a random instruction; memory accesses are mostly aimed in range on the mirrored state.
    task automatic random_instr(output t_instr ins);
        int unsigned r;
        logic [2:0]  sz;
        logic [31:0] addr, diff;
        ins.pc  = $urandom;
        ins.rs  = 5'($urandom_range(31));
        ins.rt  = 5'($urandom_range(31));
        ins.imm = 16'($urandom);
        // Keep some program counters close to the signed overflow boundary.
        if ($urandom_range(3) == 0)
            ins.pc = 32'h7ffe_0000 + $urandom_range(32'h3_ffff);
        r = $urandom_range(99);
        if (r < 8) begin
            ins.op = 6'($urandom_range(63));
        end else if (r < 48) begin
            case ($urandom_range(7))
                0: ins.op = mite_pkg::OP_LW;
                1: ins.op = mite_pkg::OP_LH;
                2: ins.op = mite_pkg::OP_LHU;
                3: ins.op = mite_pkg::OP_LB;
                4: ins.op = mite_pkg::OP_LBU;
                5: ins.op = mite_pkg::OP_SW;
                6: ins.op = mite_pkg::OP_SH;
                default: ins.op = mite_pkg::OP_SB;
            endcase
            sz = mem_size(ins.op);
            if ($urandom_range(9) != 0) begin
                // Aim at a real address; a small window makes loads hit earlier stores.
                r = $urandom_range(99);
                if (r < 50)
                    addr = $urandom_range(63);
                else if (r < 85)
                    addr = $urandom_range(mite_pkg::DMEM_BYTES - 1);
                else
                    addr = 32'(mite_pkg::DMEM_BYTES) - $urandom_range(8);
                if ($urandom_range(9) != 0)
                    addr = addr & ~(32'(sz) - 32'd1);
                diff = addr - gpr[ins.rs];
                if ($signed(diff) >= -32768 && $signed(diff) <= 32767) begin
                    ins.imm = diff[15:0];
                end else begin
                    ins.rs  = 5'd0;
                    ins.imm = addr[15:0];
                end
            end
        end else if (r < 63) begin
            case ($urandom_range(2))
                0: ins.op = mite_pkg::OP_BEQ;
                1: ins.op = mite_pkg::OP_BNE;
                default: ins.op = mite_pkg::OP_BGTZ;
            endcase
            if ($urandom_range(3) == 0)
                ins.rt = ins.rs;
        end else begin
            case ($urandom_range(6))
                0: ins.op = mite_pkg::OP_ADDI;
                1: ins.op = mite_pkg::OP_ADDIU;
                2: ins.op = mite_pkg::OP_LUI;
                3: ins.op = mite_pkg::OP_ANDI;
                4: ins.op = mite_pkg::OP_ORI;
                5: ins.op = mite_pkg::OP_NORI;
                default: ins.op = mite_pkg::OP_SLTI;
            endcase
            // Load small base pointers now and then.
            if ($urandom_range(9) < 4 && ins.op != mite_pkg::OP_LUI) begin
                ins.op  = ($urandom_range(1) == 0) ? mite_pkg::OP_ADDI : mite_pkg::OP_ADDIU;
                ins.rs  = 5'd0;
                ins.imm = 16'($urandom_range(mite_pkg::DMEM_BYTES - 1));
            end
        end
    endtask

    // Result receiver: random back-pressure plus one long hold-off on request.
    int unsigned hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_left == 0 && rx_hold_request) begin
            hold_left       = RX_HOLD_CYCLES;
            rx_hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Compare each result transaction with the oldest expectation.
    t_result got_res, want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_res = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got_res);
                n_errors++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("next_pc", want_res.npc, got_res.npc);
                check_field("reg_written", 32'(want_res.wr), 32'(got_res.wr));
                check_field("dest_index", 32'(want_res.dest), 32'(got_res.dest));
                check_field("written_value", want_res.wval, got_res.wval);
                check_field("zero_write_fault", 32'(want_res.zwf), 32'(got_res.zwf));
                check_field("number_overflow", 32'(want_res.ovf), 32'(got_res.ovf));
                check_field("address_fault", 32'(want_res.afl), 32'(got_res.afl));
                check_field("misaligned_fault", 32'(want_res.mis), 32'(got_res.mis));
                check_field("illegal_opcode", 32'(want_res.ill), 32'(got_res.ill));
                check_field("pad", 32'(want_res.pad), 32'(got_res.pad));
            end
        end
    end

    // Main sequence.
    initial begin
        t_instr   ins;
        t_dir_row row;
        foreach (gpr[k])
            gpr[k] = '0;
        foreach (dmem[k])
            dmem[k] = '0;

        // Directed table; state starts from reset, so registers are tracked row by row.
        row.typed = 1'b0;
        row.res   = '0;
        row.ins = instr(OP_TOP, 5'd31, 5'd31, 16'hffff, 32'hffff_ffff);
        row.typed = 1'b1;
        row.res = outcome(32'hffff_ffff, 1'b0, 5'd0, 32'd0,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        dir_tab.push_back(row);
        row.ins = instr(OP_SPECIAL, 5'd0, 5'd0, 16'h0000, 32'h0000_0000);
        row.res = outcome(32'h0000_0000, 1'b0, 5'd0, 32'd0,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_ADDI, 5'd0, 5'd0, 16'h0005, 32'h0000_0100);
        row.res = outcome(32'h0000_0100, 1'b0, 5'd0, 32'd0,
                          1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LUI, 5'd0, 5'd1, 16'h7fff, 32'h0000_0104);
        row.res = outcome(32'h0000_0104, 1'b1, 5'd1, 32'h7fff_0000,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab.push_back(row);
        row.typed = 1'b0;
        row.res   = '0;
        // r1 becomes the largest positive value, then add overflow with and without trap.
        row.ins = instr(mite_pkg::OP_ORI, 5'd1, 5'd1, 16'hffff, 32'h0000_0108);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_ADDI, 5'd1, 5'd2, 16'h0001, 32'h0000_010c);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_ADDIU, 5'd1, 5'd3, 16'h0001, 32'h0000_0110);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LUI, 5'd0, 5'd4, 16'h8000, 32'h0000_0114);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_SLTI, 5'd4, 5'd6, 16'h0000, 32'h0000_0118);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_ANDI, 5'd1, 5'd8, 16'h8000, 32'h0000_011c);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_NORI, 5'd0, 5'd9, 16'h0000, 32'h0000_0120);
        dir_tab.push_back(row);
        // Memory round trips at both ends of the data memory.
        row.ins = instr(mite_pkg::OP_SW, 5'd0, 5'd1, 16'h0000, 32'h0000_0124);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LW, 5'd0, 5'd10, 16'h0000, 32'h0000_0128);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_SH, 5'd0, 5'd9, 16'd1022, 32'h0000_012c);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LH, 5'd0, 5'd11, 16'd1022, 32'h0000_0130);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LHU, 5'd0, 5'd12, 16'd1022, 32'h0000_0134);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_SB, 5'd0, 5'd1, 16'd1023, 32'h0000_0138);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LB, 5'd0, 5'd13, 16'd1023, 32'h0000_013c);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LBU, 5'd0, 5'd14, 16'd1023, 32'h0000_0140);
        dir_tab.push_back(row);
        // Faulting accesses: out of range, misaligned, and both at once.
        row.typed = 1'b1;
        row.ins = instr(mite_pkg::OP_LW, 5'd0, 5'd15, 16'd1024, 32'h0000_0144);
        row.res = outcome(32'h0000_0144, 1'b0, 5'd0, 32'd0,
                          1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LW, 5'd0, 5'd16, 16'd2, 32'h0000_0148);
        row.res = outcome(32'h0000_0148, 1'b0, 5'd0, 32'd0,
                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_LW, 5'd0, 5'd17, 16'd1022, 32'h0000_014c);
        row.res = outcome(32'h0000_014c, 1'b0, 5'd0, 32'd0,
                          1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        dir_tab.push_back(row);
        row.typed = 1'b0;
        row.res   = '0;
        // Load into register zero still checks its address.
        row.ins = instr(mite_pkg::OP_LW, 5'd0, 5'd0, 16'h0000, 32'h0000_0150);
        dir_tab.push_back(row);
        // Branches with target overflow, not taken, and taken backward from the top.
        row.ins = instr(mite_pkg::OP_BEQ, 5'd0, 5'd0, 16'h7fff, 32'h7fff_fff0);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_BNE, 5'd1, 5'd1, 16'h8000, 32'h0000_0000);
        dir_tab.push_back(row);
        row.ins = instr(mite_pkg::OP_BGTZ, 5'd1, 5'd0, 16'h8000, 32'hffff_fffc);
        dir_tab.push_back(row);

        // Reset; the unit then clears its data memory before taking any transaction.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k])
            send_instr(dir_tab[k].ins, dir_tab[k].typed, dir_tab[k].res);
        drain_results();

        // Random programs under three back-pressure settings.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 13;
                    rx_idle_pct = 76;
                end
                1: begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 13;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 0 && k == 100)
                    rx_hold_request = 1'b1;
                if (k == 300)
                    drain_results();
                random_instr(ins);
                send_instr(ins, 1'b0, '0);
            end
        end

        // Let the pipeline empty, then report.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("mips_itype_execute_with_faults: match");
        end else begin
            $display("mips_itype_execute_with_faults: mismatch");
        end
        $finish;
    end

endmodule
